// ===== sv/ucbs_pkg.sv =====
// ucbs_pkg: shared types and constants for the clause branch selector
// opcodes, sequencer states, request and result records
// no dependencies
`default_nettype none
package ucbs_pkg;

	localparam int MAX_VARS_DEF       = 1024;
	localparam int MAX_CLAUSE_LEN_DEF = 32;
	localparam int COUNT_WIDTH_DEF    = 16;

	localparam int VAR_W      = 10;
	localparam int BEST_W     = 16;
	localparam int RAND_W     = 32;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 32;

	localparam logic [VAR_W-1:0] NUM_VARS_RESET = 10'd1023;

	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_SET_FLAG = 2'd1,
		OP_LITERAL  = 2'd2,
		OP_SELECT   = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_LIT,
		ST_BUF_RD,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_CLEAR,
		ST_SCAN1,
		ST_DIV,
		ST_SCAN2,
		ST_EMIT
	} state_t;

	typedef struct packed {
		opcode_t           opcode;
		logic [VAR_W-1:0]  var_index;
		logic              free_flag;
		logic              lit_true;
		logic              clause_always_sat;
		logic              last_in_clause;
		logic [RAND_W-1:0] random_value;
	} req_t;

	typedef struct packed {
		logic              result_kind;
		logic              clause_presat;
		logic              clause_overflow;
		logic [VAR_W-1:0]  branch_var;
		logic [BEST_W-1:0] best_count;
		logic              all_resolved;
	} res_t;

	typedef struct packed {
		logic cnt_we;
		logic flg_we;
		logic flg_wr_data;
	} mem_ctl_t;

endpackage
`default_nettype wire

// ===== sv/ucbs_store.sv =====
// ucbs_store: occurrence count memory and free flag memory
// one write and one registered read port each; uses ucbs_pkg
`default_nettype none
module ucbs_store #(
	parameter int MAX_VARS    = ucbs_pkg::MAX_VARS_DEF,
	parameter int COUNT_WIDTH = ucbs_pkg::COUNT_WIDTH_DEF
) (
	input  wire                             clk,
	input  ucbs_pkg::mem_ctl_t              ctl,
	input  wire  [$clog2(MAX_VARS)-1:0]     cnt_rd_addr,
	input  wire  [$clog2(MAX_VARS)-1:0]     cnt_wr_addr,
	input  wire  [COUNT_WIDTH-1:0]          cnt_wr_data,
	output logic [COUNT_WIDTH-1:0]          cnt_rd_data,
	input  wire  [$clog2(MAX_VARS)-1:0]     flg_rd_addr,
	input  wire  [$clog2(MAX_VARS)-1:0]     flg_wr_addr,
	output logic                            flg_rd_data
);
	import ucbs_pkg::*;

	logic [COUNT_WIDTH-1:0] cnt_mem [MAX_VARS];
	logic                   flg_mem [MAX_VARS];

	always_ff @(posedge clk) begin
		if (ctl.cnt_we) begin
			cnt_mem[cnt_wr_addr] <= cnt_wr_data;
		end
		cnt_rd_data <= cnt_mem[cnt_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.flg_we) begin
			flg_mem[flg_wr_addr] <= ctl.flg_wr_data;
		end
		flg_rd_data <= flg_mem[flg_rd_addr];
	end

endmodule
`default_nettype wire

// ===== sv/ucbs_divmod.sv =====
// ucbs_divmod: restoring remainder unit, one dividend bit per cycle
// gives random word mod tie count; uses ucbs_pkg
`default_nettype none
module ucbs_divmod #(
	parameter int DW = 11
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire  [ucbs_pkg::RAND_W-1:0]    dividend,
	input  wire  [DW-1:0]                  divisor,
	output logic                           done,
	output logic [DW-1:0]                  remainder
);
	import ucbs_pkg::*;

	localparam int CW = $clog2(RAND_W + 1);

	logic          busy_q;
	logic [CW-1:0] step_q;
	logic [RAND_W-1:0] dvd_q;
	logic [DW-1:0] dsr_q;
	logic [DW-1:0] rem_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW-1:0] rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[RAND_W-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = DW'(trial - {1'b0, dsr_q});
		end else begin
			rem_next = trial[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (step_q == CW'(RAND_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + CW'(1);
				if (step_q == CW'(RAND_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RAND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// ===== sv/ucbs_ctrl.sv =====
// ucbs_ctrl: sequencer with clause buffer, count update loop and variable scans
// drives ucbs_store and ucbs_divmod; uses ucbs_pkg
`default_nettype none
module ucbs_ctrl #(
	parameter int MAX_VARS       = ucbs_pkg::MAX_VARS_DEF,
	parameter int MAX_CLAUSE_LEN = ucbs_pkg::MAX_CLAUSE_LEN_DEF,
	parameter int COUNT_WIDTH    = ucbs_pkg::COUNT_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	input  ucbs_pkg::req_t                   req,
	output logic                             in_ready,
	input  wire  [ucbs_pkg::VAR_W-1:0]       num_vars,
	input  wire                              out_free,
	output logic                             res_valid,
	output ucbs_pkg::res_t                   res,
	output ucbs_pkg::mem_ctl_t               mem_ctl,
	output logic [$clog2(MAX_VARS)-1:0]      cnt_rd_addr,
	output logic [$clog2(MAX_VARS)-1:0]      cnt_wr_addr,
	output logic [COUNT_WIDTH-1:0]           cnt_wr_data,
	input  wire  [COUNT_WIDTH-1:0]           cnt_rd_data,
	output logic [$clog2(MAX_VARS)-1:0]      flg_rd_addr,
	output logic [$clog2(MAX_VARS)-1:0]      flg_wr_addr,
	input  wire                              flg_rd_data,
	output logic                             div_start,
	output logic [ucbs_pkg::RAND_W-1:0]      div_dividend,
	output logic [$clog2(MAX_VARS):0]        div_divisor,
	input  wire                              div_done,
	input  wire  [$clog2(MAX_VARS):0]        div_rem
);
	import ucbs_pkg::*;

	localparam int VAW  = $clog2(MAX_VARS);
	localparam int VMAX = MAX_VARS - 1;
	localparam int LW   = $clog2(MAX_CLAUSE_LEN + 1);
	localparam int LIW  = $clog2(MAX_CLAUSE_LEN);
	localparam logic [COUNT_WIDTH-1:0] CNT_TOP = {COUNT_WIDTH{1'b1}};

	state_t state_q, state_d;

	logic [VAW:0]       a_q;
	logic [VAW:0]       top_q;
	logic [VAW:0]       top_w;
	logic               p_valid_s1;
	logic [VAW-1:0]     p_idx_s1;
	logic               issue;
	logic               scan_end;

	logic [VAR_W-1:0]   buf_mem [MAX_CLAUSE_LEN];
	logic [VAR_W-1:0]   buf_rd_q;
	logic [LW-1:0]      len_q;
	logic [LW-1:0]      idx_q;
	logic [VAW-1:0]     w_q;

	logic               seen_free_q;
	logic               seen_true_q;
	logic               seen_taut_q;
	logic               seen_ovf_q;
	logic               all_res_q;
	logic               in_range_q;
	logic               lit_true_q;
	logic               last_q;

	logic               kind_q;
	logic               presat_q;
	logic               ovf_q;
	logic               any_q;
	logic               found_q;
	logic [COUNT_WIDTH-1:0] best_q;
	logic [VAW:0]       ties_q;
	logic [VAW:0]       seen_q;
	logic [VAW-1:0]     chosen_q;
	logic [RAND_W-1:0]  rand_q;

	logic               accept;
	logic               v_in_range;
	logic [VAW-1:0]     v_addr;
	logic               free_now;
	logic               true_now;
	logic               resolved;
	logic [31:0]        best_ext;

	assign accept     = in_valid && in_ready;
	assign v_in_range = 32'(req.var_index) < 32'(MAX_VARS);
	assign v_addr     = VAW'(req.var_index);
	assign issue      = (a_q <= top_q);
	assign scan_end   = !issue && !p_valid_s1;

	assign free_now = seen_free_q || (in_range_q && flg_rd_data);
	assign true_now = seen_true_q || (in_range_q && !flg_rd_data && lit_true_q);
	assign resolved = seen_taut_q || true_now || !free_now;

	always_comb begin
		if (32'(num_vars) > 32'(VMAX)) begin
			top_w = (VAW+1)'(VMAX);
		end else begin
			top_w = (VAW+1)'(num_vars);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (a_q == (VAW+1)'(VMAX)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (req.opcode)
						OP_CLEAR:    state_d = ST_CLEAR;
						OP_SET_FLAG: state_d = ST_IDLE;
						OP_LITERAL:  state_d = ST_LIT;
						OP_SELECT:   state_d = (top_w == '0) ? ST_EMIT : ST_SCAN1;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_LIT: begin
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (resolved) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_BUF_RD;
				end
			end
			ST_BUF_RD: state_d = ST_CNT_RD;
			ST_CNT_RD: state_d = ST_CNT_WR;
			ST_CNT_WR: begin
				state_d = (idx_q + LW'(1) == len_q) ? ST_EMIT : ST_BUF_RD;
			end
			ST_CLEAR: begin
				if (a_q == (VAW+1)'(VMAX)) state_d = ST_IDLE;
			end
			ST_SCAN1: begin
				if (scan_end) state_d = any_q ? ST_DIV : ST_EMIT;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_SCAN2;
			end
			ST_SCAN2: begin
				if (scan_end) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready            = (state_q == ST_IDLE);
		res_valid           = (state_q == ST_EMIT) && out_free;
		div_start           = (state_q == ST_SCAN1) && scan_end && any_q;
		div_divisor         = ties_q;
		mem_ctl.cnt_we      = 1'b0;
		mem_ctl.flg_we      = 1'b0;
		mem_ctl.flg_wr_data = 1'b1;
		cnt_wr_addr         = a_q[VAW-1:0];
		cnt_wr_data         = '0;
		flg_wr_addr         = a_q[VAW-1:0];
		flg_rd_addr         = a_q[VAW-1:0];
		cnt_rd_addr         = a_q[VAW-1:0];
		case (state_q)
			ST_INIT: begin
				mem_ctl.cnt_we = 1'b1;
				mem_ctl.flg_we = 1'b1;
			end
			ST_CLEAR: begin
				mem_ctl.cnt_we = 1'b1;
			end
			ST_IDLE: begin
				flg_rd_addr         = v_addr;
				flg_wr_addr         = v_addr;
				mem_ctl.flg_wr_data = req.free_flag;
				mem_ctl.flg_we      = accept && (req.opcode == OP_SET_FLAG) && v_in_range;
			end
			ST_CNT_RD: begin
				cnt_rd_addr = VAW'(buf_rd_q);
			end
			ST_CNT_WR: begin
				cnt_wr_addr    = w_q;
				cnt_wr_data    = cnt_rd_data + COUNT_WIDTH'(1);
				mem_ctl.cnt_we = (cnt_rd_data != CNT_TOP);
			end
			default: begin
			end
		endcase
	end

	assign best_ext     = 32'(best_q);
	assign div_dividend = rand_q;

	always_comb begin
		res.result_kind     = kind_q;
		res.clause_presat   = presat_q;
		res.clause_overflow = ovf_q;
		res.branch_var      = kind_q ? VAR_W'(chosen_q) : '0;
		res.best_count      = kind_q ? best_ext[BEST_W-1:0] : '0;
		res.all_resolved    = all_res_q;
	end

	// clause buffer
	always_ff @(posedge clk) begin
		if (accept && (req.opcode == OP_LITERAL) && v_in_range
				&& (len_q < LW'(MAX_CLAUSE_LEN))) begin
			buf_mem[len_q[LIW-1:0]] <= req.var_index;
		end
		buf_rd_q <= buf_mem[idx_q[LIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			a_q         <= '0;
			top_q       <= '0;
			p_valid_s1  <= 1'b0;
			len_q       <= '0;
			idx_q       <= '0;
			seen_free_q <= 1'b0;
			seen_true_q <= 1'b0;
			seen_taut_q <= 1'b0;
			seen_ovf_q  <= 1'b0;
			all_res_q   <= 1'b1;
			any_q       <= 1'b0;
			found_q     <= 1'b0;
			ties_q      <= '0;
			seen_q      <= '0;
		end else begin
			state_q    <= state_d;
			p_valid_s1 <= ((state_q == ST_SCAN1) || (state_q == ST_SCAN2)) && issue;
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					a_q <= a_q + (VAW+1)'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						case (req.opcode)
							OP_CLEAR: begin
								a_q         <= '0;
								all_res_q   <= 1'b1;
								len_q       <= '0;
								seen_free_q <= 1'b0;
								seen_true_q <= 1'b0;
								seen_taut_q <= 1'b0;
								seen_ovf_q  <= 1'b0;
							end
							OP_LITERAL: begin
								if (req.clause_always_sat) seen_taut_q <= 1'b1;
								if (v_in_range) begin
									if (len_q < LW'(MAX_CLAUSE_LEN)) begin
										len_q <= len_q + LW'(1);
									end else begin
										seen_ovf_q <= 1'b1;
									end
								end
							end
							OP_SELECT: begin
								a_q     <= (VAW+1)'(1);
								top_q   <= top_w;
								any_q   <= 1'b0;
								found_q <= 1'b0;
								ties_q  <= '0;
								seen_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LIT: begin
					if (last_q) begin
						seen_free_q <= 1'b0;
						seen_true_q <= 1'b0;
						seen_taut_q <= 1'b0;
						seen_ovf_q  <= 1'b0;
						idx_q       <= '0;
						if (resolved) begin
							len_q <= '0;
						end else begin
							all_res_q <= 1'b0;
						end
					end else begin
						seen_free_q <= free_now;
						seen_true_q <= true_now;
					end
				end
				ST_CNT_WR: begin
					idx_q <= idx_q + LW'(1);
					if (idx_q + LW'(1) == len_q) len_q <= '0;
				end
				ST_SCAN1, ST_SCAN2: begin
					if (issue) a_q <= a_q + (VAW+1)'(1);
					if (state_q == ST_SCAN1) begin
						if (p_valid_s1 && flg_rd_data) begin
							if (!any_q || cnt_rd_data > best_q) begin
								ties_q <= (VAW+1)'(1);
								any_q  <= 1'b1;
							end else if (cnt_rd_data == best_q) begin
								ties_q <= ties_q + (VAW+1)'(1);
							end
						end
						if (scan_end) a_q <= (VAW+1)'(1);
					end else begin
						if (p_valid_s1 && flg_rd_data && cnt_rd_data == best_q) begin
							seen_q <= seen_q + (VAW+1)'(1);
							if (seen_q == div_rem && !found_q) found_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					in_range_q <= v_in_range;
					lit_true_q <= req.lit_true;
					last_q     <= req.last_in_clause;
					rand_q     <= req.random_value;
					if (req.opcode == OP_SELECT) begin
						kind_q   <= 1'b1;
						presat_q <= 1'b0;
						ovf_q    <= 1'b0;
						best_q   <= '0;
						chosen_q <= '0;
					end
				end
			end
			ST_LIT: begin
				kind_q   <= 1'b0;
				presat_q <= resolved;
				ovf_q    <= seen_ovf_q;
			end
			ST_CNT_RD: begin
				w_q <= VAW'(buf_rd_q);
			end
			ST_SCAN1: begin
				p_idx_s1 <= a_q[VAW-1:0];
				if (p_valid_s1 && flg_rd_data && (!any_q || cnt_rd_data > best_q)) begin
					best_q <= cnt_rd_data;
				end
			end
			ST_SCAN2: begin
				p_idx_s1 <= a_q[VAW-1:0];
				if (p_valid_s1 && flg_rd_data && cnt_rd_data == best_q
						&& seen_q == div_rem && !found_q) begin
					chosen_q <= p_idx_s1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/unresolved_clause_branch_select.sv =====
// unresolved_clause_branch_select: top level, stream ports, config register,
// output register; instantiates ucbs_ctrl, ucbs_store, ucbs_divmod; uses ucbs_pkg
//
//   channel   direction  handshake                       payload
//   s_axis    in         s_axis_tvalid / s_axis_tready   tdata, tuser (opcode), tlast
//   m_axis    out        m_axis_tvalid / m_axis_tready   tdata, tuser (result_kind)
//   cfg       in         cfg_we                          cfg_wdata (num_vars)
//
// clear: one count entry written per cycle, over all MAX_VARS entries
// set flag: written when taken; literal: through the literal state, and at clause
//   end a status result after a count memory read-modify-write (buffer read, count
//   read, count write) per buffered variable when the clause is unresolved
// select: two passes over the count memory, and a 32-step remainder unit in between
//   when the first pass finds a free variable
// after reset a pass over all entries clears counts and sets free flags; no request
//   is taken meanwhile. while the output register is full the next result waits in
//   the sequencer, and no request is taken until that register drains
`default_nettype none
module unresolved_clause_branch_select #(
	parameter int MAX_VARS       = ucbs_pkg::MAX_VARS_DEF,
	parameter int MAX_CLAUSE_LEN = ucbs_pkg::MAX_CLAUSE_LEN_DEF,
	parameter int COUNT_WIDTH    = ucbs_pkg::COUNT_WIDTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// var_index[9:0], free_flag[10], lit_true[11], clause_always_sat[12],
	// random_value[44:13], zero[47:45]
	input  wire  [ucbs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// opcode[1:0]
	input  wire  [1:0]                          s_axis_tuser,
	input  wire                                 s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// clause_presat[0], clause_overflow[1], branch_var[11:2], best_count[27:12],
	// all_resolved[28], zero[31:29]
	output logic [ucbs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// result_kind[0]
	output logic [0:0]                          m_axis_tuser,
	input  wire                                 cfg_we,
	input  wire  [ucbs_pkg::VAR_W-1:0]          cfg_wdata
);
	import ucbs_pkg::*;

	localparam int VAW = $clog2(MAX_VARS);

	logic [VAR_W-1:0] num_vars_q;
	logic             out_valid_q;
	res_t             out_res_q;
	req_t             req;
	res_t             res;
	logic             res_valid;
	logic             out_free;
	mem_ctl_t         mem_ctl;
	logic [VAW-1:0]   cnt_rd_addr;
	logic [VAW-1:0]   cnt_wr_addr;
	logic [COUNT_WIDTH-1:0] cnt_wr_data;
	logic [COUNT_WIDTH-1:0] cnt_rd_data;
	logic [VAW-1:0]   flg_rd_addr;
	logic [VAW-1:0]   flg_wr_addr;
	logic             flg_rd_data;
	logic             div_start;
	logic [RAND_W-1:0] div_dividend;
	logic [VAW:0]     div_divisor;
	logic             div_done;
	logic [VAW:0]     div_rem;

	always_comb begin
		req.opcode            = opcode_t'(s_axis_tuser);
		req.var_index         = s_axis_tdata[9:0];
		req.free_flag         = s_axis_tdata[10];
		req.lit_true          = s_axis_tdata[11];
		req.clause_always_sat = s_axis_tdata[12];
		req.random_value      = s_axis_tdata[44:13];
		req.last_in_clause    = s_axis_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q <= NUM_VARS_RESET;
		end else if (cfg_we) begin
			num_vars_q <= cfg_wdata;
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_res_q <= res;
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tuser[0] = out_res_q.result_kind;
	assign m_axis_tdata    = {3'b000, out_res_q.all_resolved, out_res_q.best_count,
		out_res_q.branch_var, out_res_q.clause_overflow, out_res_q.clause_presat};

	ucbs_ctrl #(
		.MAX_VARS       (MAX_VARS),
		.MAX_CLAUSE_LEN (MAX_CLAUSE_LEN),
		.COUNT_WIDTH    (COUNT_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.req          (req),
		.in_ready     (s_axis_tready),
		.num_vars     (num_vars_q),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res          (res),
		.mem_ctl      (mem_ctl),
		.cnt_rd_addr  (cnt_rd_addr),
		.cnt_wr_addr  (cnt_wr_addr),
		.cnt_wr_data  (cnt_wr_data),
		.cnt_rd_data  (cnt_rd_data),
		.flg_rd_addr  (flg_rd_addr),
		.flg_wr_addr  (flg_wr_addr),
		.flg_rd_data  (flg_rd_data),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_rem      (div_rem)
	);

	ucbs_store #(
		.MAX_VARS    (MAX_VARS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_store (
		.clk         (clk),
		.ctl         (mem_ctl),
		.cnt_rd_addr (cnt_rd_addr),
		.cnt_wr_addr (cnt_wr_addr),
		.cnt_wr_data (cnt_wr_data),
		.cnt_rd_data (cnt_rd_data),
		.flg_rd_addr (flg_rd_addr),
		.flg_wr_addr (flg_wr_addr),
		.flg_rd_data (flg_rd_data)
	);

	ucbs_divmod #(
		.DW (VAW + 1)
	) u_divmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.remainder (div_rem)
	);

endmodule
`default_nettype wire

// ===== sv/ucbs_checker.sv =====
// ucbs_checker: port-level checks for unresolved_clause_branch_select
// bound to the top level below; uses ucbs_pkg
`default_nettype none
module ucbs_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 s_axis_tvalid,
	input wire                                 s_axis_tready,
	input wire [ucbs_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	input wire [1:0]                           s_axis_tuser,
	input wire                                 s_axis_tlast,
	input wire                                 m_axis_tvalid,
	input wire                                 m_axis_tready,
	input wire [ucbs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input wire [0:0]                           m_axis_tuser,
	input wire                                 cfg_we,
	input wire [ucbs_pkg::VAR_W-1:0]           cfg_wdata
);
	import ucbs_pkg::*;

	// clause status carries no branch variable or count
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[27:2] == 26'd0)
		else $error("clause status with branch fields set");

	// selection answer carries no clause flags
	a_select_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[1:0] == 2'd0)
		else $error("selection answer with clause flags set");

	// no candidate means zero count
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[11:2] == 10'd0
		|-> m_axis_tdata[27:12] == 16'd0)
		else $error("no branch variable but nonzero count");

	// a select request keeps the block busy for at least the next cycle
	a_select_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SELECT |=> !s_axis_tready)
		else $error("request taken right after select");

	logic unused_ports;
	assign unused_ports = ^{s_axis_tdata, s_axis_tlast, m_axis_tready, cfg_we, cfg_wdata};

endmodule

bind unresolved_clause_branch_select ucbs_checker u_checker (.*);
`default_nettype wire
